// File: design/swdd_pkg.sv
// Shared types and constants for the screen write dirty decoder.
// Used by swdd_front, swdd_fifo, swdd_back and screen_write_dirty_decode.
package swdd_pkg;

  localparam logic [3:0] MODE_STANDARD    = 4'd0;
  localparam logic [3:0] MODE_ALT_FILE    = 4'd1;
  localparam logic [3:0] MODE_EXT_COL     = 4'd2;
  localparam logic [3:0] MODE_EXT_COL_ALT = 4'd3;
  localparam logic [3:0] MODE_HIRES_ATTR  = 4'd4;
  localparam logic [3:0] MODE_HIRES_ATTRA = 4'd5;
  localparam logic [3:0] MODE_HIRES       = 4'd6;
  localparam logic [3:0] MODE_HIRES_DBL   = 4'd7;
  localparam logic [3:0] MODE_SIXTEEN_COL = 4'd8;

  localparam int unsigned OFFSET_W = 14;
  localparam int unsigned COL_W    = 5;
  localparam int unsigned LINE_W   = 8;
  localparam int unsigned MODE_W   = 4;
  localparam int unsigned PADDR_W  = 2;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [PADDR_W-1:0] REG_SCREEN_MODE = 2'd0;

  // Attribute bytes of a file sit at relative offset bits 12..8 = 0x18..0x1A
  localparam logic [4:0] ATTR_PAGE_FIRST = 5'h18;
  localparam logic [4:0] ATTR_PAGE_LAST  = 5'h1A;

  localparam logic [2:0] CELL_LAST_STEP = 3'd7;

  // One classified write waiting for the back end
  typedef struct packed {
    logic              attr;   // expand to eight lines of a character cell
    logic [COL_W-1:0]  col;
    logic [LINE_W-1:0] line;   // pixel line, or top line of the cell
  } chunk_job_t;

endpackage

// File: design/screen_write_dirty_decode.sv
// Screen write dirty decoder: top level with mode register and APB port.
// An accepted write goes into the job queue; its words are then registered at the output.
// Throughput: one write per cycle in while not full, one chunk word per cycle out
// while pop is held; an attribute write gives eight words, a pixel write one.
// Reset (rst_n low, synchronous): queue and output empty, screen_mode 0.
// Depends on swdd_pkg, swdd_front, swdd_fifo, swdd_back.
module screen_write_dirty_decode #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  output logic                           full,
  input  logic [swdd_pkg::OFFSET_W-1:0]  in_write_offset,
  output logic                           empty,
  input  logic                           pop,
  output logic [swdd_pkg::COL_W-1:0]     out_chunk_column,
  output logic [swdd_pkg::LINE_W-1:0]    out_screen_line,
  output logic                           out_last_of_run,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swdd_pkg::PADDR_W-1:0]   paddr,
  input  logic [swdd_pkg::PDATA_W-1:0]   pwdata,
  output logic [swdd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [swdd_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic                        keep;
  swdd_pkg::chunk_job_t        front_job;
  swdd_pkg::chunk_job_t        head_job;
  logic                        head_valid;
  logic                        head_done;
  logic                        q_full;

  assign pready = 1'b1;
  assign prdata = (paddr == swdd_pkg::REG_SCREEN_MODE) ?
                  {{(swdd_pkg::PDATA_W-swdd_pkg::MODE_W){1'b0}}, mode_r} : '0;

  always_comb begin
    mode_nxt = mode_r;
    if (psel && penable && pwrite && paddr == swdd_pkg::REG_SCREEN_MODE) begin
      mode_nxt = pwdata[swdd_pkg::MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= swdd_pkg::MODE_STANDARD;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  swdd_front u_front (
    .mode   (mode_r),
    .offset (in_write_offset),
    .keep   (keep),
    .job    (front_job)
  );

  assign full = q_full;

  // drop writes that touch nothing on screen
  swdd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (push && keep),
    .wr_job    (front_job),
    .rd_en     (head_done),
    .rd_job    (head_job),
    .not_empty (head_valid),
    .is_full   (q_full)
  );

  swdd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_valid    (head_valid),
    .job          (head_job),
    .job_done     (head_done),
    .empty        (empty),
    .pop          (pop),
    .chunk_column (out_chunk_column),
    .screen_line  (out_screen_line),
    .last_of_run  (out_last_of_run)
  );

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_screen_line < 8'd192)
    else $error("screen line out of range");

  a_cell_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last_of_run) |-> out_screen_line[2:0] != 3'd7)
    else $error("bottom line of a cell not flagged last");

  a_cell_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last_of_run) |=>
      (!empty && out_screen_line == $past(out_screen_line) + 8'd1))
    else $error("attribute run did not advance to the next line");
`endif

endmodule

// File: design/swdd_front.sv
// Front end: classifies one write offset against the screen mode.
// Depends on swdd_pkg.
module swdd_front (
  input  logic [swdd_pkg::MODE_W-1:0]   mode,
  input  logic [swdd_pkg::OFFSET_W-1:0] offset,
  output logic                          keep,
  output swdd_pkg::chunk_job_t          job
);

  logic        alt;
  logic [12:0] rel;
  logic        is_pix;
  logic        is_attr;

  assign alt     = offset[13];
  assign rel     = offset[12:0];
  assign is_pix  = (rel[12:11] != 2'b11);
  assign is_attr = (rel[12:8] >= swdd_pkg::ATTR_PAGE_FIRST) &&
                   (rel[12:8] <= swdd_pkg::ATTR_PAGE_LAST);

  always_comb begin
    job.col = rel[4:0];
    job.attr = !is_pix;
    if (is_pix) begin
      // interleaved layout: third, character row, pixel row
      job.line = {rel[12:11], rel[7:5], rel[10:8]};
    end else begin
      job.line = {rel[9:5], 3'b000};
    end
  end

  always_comb begin
    unique case (mode)
      swdd_pkg::MODE_STANDARD, swdd_pkg::MODE_HIRES_ATTR: begin
        keep = !alt && (is_pix || is_attr);
      end
      swdd_pkg::MODE_ALT_FILE, swdd_pkg::MODE_HIRES_ATTRA: begin
        keep = alt && (is_pix || is_attr);
      end
      swdd_pkg::MODE_EXT_COL, swdd_pkg::MODE_HIRES, swdd_pkg::MODE_SIXTEEN_COL: begin
        keep = is_pix;
      end
      swdd_pkg::MODE_EXT_COL_ALT, swdd_pkg::MODE_HIRES_DBL: begin
        keep = alt && is_pix;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

endmodule

// File: design/swdd_fifo.sv
// Short job queue between front and back end.
// Depends on swdd_pkg.
module swdd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  swdd_pkg::chunk_job_t wr_job,
  input  logic                 rd_en,
  output swdd_pkg::chunk_job_t rd_job,
  output logic                 not_empty,
  output logic                 is_full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  swdd_pkg::chunk_job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign not_empty = (count_r != '0);
  assign is_full   = (count_r == CNT_FULL);
  assign do_wr     = wr_en && !is_full;
  assign do_rd     = rd_en && not_empty;
  assign rd_job    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

// File: design/swdd_back.sv
// Back end: expands queued jobs into chunk words, one per cycle while words are popped.
// Depends on swdd_pkg.
module swdd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_valid,
  input  swdd_pkg::chunk_job_t          job,
  output logic                          job_done,
  output logic                          empty,
  input  logic                          pop,
  output logic [swdd_pkg::COL_W-1:0]    chunk_column,
  output logic [swdd_pkg::LINE_W-1:0]   screen_line,
  output logic                          last_of_run
);

  logic                        out_valid_r, out_valid_nxt;
  logic [swdd_pkg::COL_W-1:0]  col_r;
  logic [swdd_pkg::LINE_W-1:0] line_r;
  logic                        last_r;
  logic [2:0]                  step_r, step_nxt;
  logic                        load;
  logic                        gen_last;
  logic [swdd_pkg::LINE_W-1:0] gen_line;

  assign load     = job_valid && (!out_valid_r || pop);
  assign gen_last = !job.attr || (step_r == swdd_pkg::CELL_LAST_STEP);
  assign gen_line = job.attr ? {job.line[swdd_pkg::LINE_W-1:3], step_r} : job.line;
  assign job_done = load && gen_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    step_nxt      = step_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      step_nxt      = gen_last ? 3'd0 : step_r + 3'd1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // hold the word until popped
  always_ff @(posedge clk) begin
    if (load) begin
      col_r  <= job.col;
      line_r <= gen_line;
      last_r <= gen_last;
    end
  end

  assign empty        = !out_valid_r;
  assign chunk_column = col_r;
  assign screen_line  = line_r;
  assign last_of_run  = last_r;

endmodule

// File: tb/dirty_chunk_checker.sv
// Checker for the screen write dirty decoder: predicts the chunk words of each
// accepted write and compares them with the words the block hands out.
// Depends on swdd_pkg for widths, mode codes and the register address.
module dirty_chunk_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic                          full,
  input  logic [swdd_pkg::OFFSET_W-1:0] in_write_offset,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [swdd_pkg::COL_W-1:0]    out_chunk_column,
  input  logic [swdd_pkg::LINE_W-1:0]   out_screen_line,
  input  logic                          out_last_of_run,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swdd_pkg::PADDR_W-1:0]  paddr,
  input  logic [swdd_pkg::PDATA_W-1:0]  pwdata,
  input  logic [swdd_pkg::PDATA_W-1:0]  prdata,
  input  logic                          pready,
  output int                            fail_count,
  output int                            pending
);

  localparam int unsigned PIXEL_BYTES   = 6144;
  localparam int unsigned FILE_SPAN     = 6912;
  localparam int unsigned ALT_FILE_BASE = 8192;
  localparam int unsigned CELL_LINES    = 8;

  typedef logic [swdd_pkg::COL_W-1:0]   col_t;
  typedef logic [swdd_pkg::LINE_W-1:0]  line_t;
  typedef logic [swdd_pkg::MODE_W-1:0]  mode_t;
  typedef logic [swdd_pkg::PDATA_W-1:0] pdata_t;

  typedef struct {
    col_t  col;
    line_t line;
    logic  last;
  } chunk_t;

  chunk_t expected_chunks[$];
  chunk_t head;
  mode_t  mode_q = swdd_pkg::MODE_STANDARD;
  int     errors = 0;

  // Interleaved layout: third in 12..11, char row in 7..5, pixel row in 10..8
  function automatic void add_pixel_chunk(input int unsigned rel);
    chunk_t         c;
    logic [13:0]    o;
    o      = rel[13:0];
    c.col  = o[4:0];
    c.line = line_t'(64 * o[12:11] + 8 * o[7:5] + o[10:8]);
    c.last = 1'b1;
    expected_chunks.push_back(c);
  endfunction

  function automatic void add_cell_chunks(input int unsigned rel);
    chunk_t      c;
    int unsigned idx;
    idx = rel - PIXEL_BYTES;
    for (int i = 0; i < CELL_LINES; i++) begin
      c.col  = col_t'(idx % 32);
      c.line = line_t'((idx / 32) * CELL_LINES + i);
      c.last = (i == CELL_LINES - 1);
      expected_chunks.push_back(c);
    end
  endfunction

  function automatic void add_file_chunks(input int unsigned rel);
    if (rel < PIXEL_BYTES) add_pixel_chunk(rel);
    else add_cell_chunks(rel);
  endfunction

  function automatic void decode_write(input logic [swdd_pkg::OFFSET_W-1:0] off);
    int unsigned o;
    o = off;
    case (mode_q)
      swdd_pkg::MODE_STANDARD, swdd_pkg::MODE_HIRES_ATTR: begin
        if (o < FILE_SPAN) add_file_chunks(o);
      end
      swdd_pkg::MODE_ALT_FILE, swdd_pkg::MODE_HIRES_ATTRA: begin
        if (o >= ALT_FILE_BASE && o < ALT_FILE_BASE + FILE_SPAN)
          add_file_chunks(o - ALT_FILE_BASE);
      end
      swdd_pkg::MODE_EXT_COL, swdd_pkg::MODE_HIRES, swdd_pkg::MODE_SIXTEEN_COL: begin
        if (o < PIXEL_BYTES) add_pixel_chunk(o);
        else if (o >= ALT_FILE_BASE && o < ALT_FILE_BASE + PIXEL_BYTES)
          add_pixel_chunk(o - ALT_FILE_BASE);
      end
      swdd_pkg::MODE_EXT_COL_ALT, swdd_pkg::MODE_HIRES_DBL: begin
        if (o >= ALT_FILE_BASE && o < ALT_FILE_BASE + PIXEL_BYTES)
          add_pixel_chunk(o - ALT_FILE_BASE);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_chunks.delete();
      mode_q = swdd_pkg::MODE_STANDARD;
    end else begin
      if (psel && penable && pready && paddr == swdd_pkg::REG_SCREEN_MODE) begin
        if (pwrite) begin
          mode_q = pwdata[swdd_pkg::MODE_W-1:0];
        end else if (prdata !== pdata_t'(mode_q)) begin
          $error("screen_mode readback: expected %0d, got %0d", mode_q, prdata);
          errors++;
        end
      end
      if (pop && !empty) begin
        if (expected_chunks.size() == 0) begin
          $error("unexpected word: column %0d line %0d last %0d",
                 out_chunk_column, out_screen_line, out_last_of_run);
          errors++;
        end else begin
          head = expected_chunks.pop_front();
          if (out_chunk_column !== head.col) begin
            $error("chunk_column: expected %0d, got %0d", head.col, out_chunk_column);
            errors++;
          end
          if (out_screen_line !== head.line) begin
            $error("screen_line: expected %0d, got %0d", head.line, out_screen_line);
            errors++;
          end
          if (out_last_of_run !== head.last) begin
            $error("last_of_run: expected %0d, got %0d", head.last, out_last_of_run);
            errors++;
          end
        end
      end
      if (push && !full) decode_write(in_write_offset);
    end
    pending    <= expected_chunks.size();
    fail_count <= errors;
  end

endmodule

// File: tb/tb.sv
// Testbench top for screen_write_dirty_decode: clock, reset, write and APB
// stimulus, and the verdict. Depends on swdd_pkg, the block and dirty_chunk_checker.
module tb;

  localparam int CLK_PERIOD     = 10;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int HOLD_CYCLES    = 90;
  localparam int SETTLE_CYCLES  = 12;
  localparam int PHASE_ITEMS    = 30;
  localparam int PHASES         = 11;

  typedef logic [swdd_pkg::OFFSET_W-1:0] offset_t;
  typedef logic [swdd_pkg::MODE_W-1:0]   mode_t;
  typedef logic [swdd_pkg::PDATA_W-1:0]  pdata_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  offset_t                       in_write_offset = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic [swdd_pkg::COL_W-1:0]    out_chunk_column;
  logic [swdd_pkg::LINE_W-1:0]   out_screen_line;
  logic                          out_last_of_run;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [swdd_pkg::PADDR_W-1:0]  paddr = '0;
  pdata_t                        pwdata = '0;
  pdata_t                        prdata;
  logic                          pready;

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  screen_write_dirty_decode i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_write_offset  (in_write_offset),
    .empty            (empty),
    .pop              (pop),
    .out_chunk_column (out_chunk_column),
    .out_screen_line  (out_screen_line),
    .out_last_of_run  (out_last_of_run),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  dirty_chunk_checker i_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_write_offset  (in_write_offset),
    .empty            (empty),
    .pop              (pop),
    .out_chunk_column (out_chunk_column),
    .out_screen_line  (out_screen_line),
    .out_last_of_run  (out_last_of_run),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Receiver: random pops, or a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

  // Offer one write; push stays high afterwards so back-to-back words flow
  task automatic send_write(input offset_t off);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push            <= 1'b1;
    in_write_offset <= off;
    do @(posedge clk); while (full);
  endtask

  // Drop push and wait until every predicted word has been popped
  task automatic drain;
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the mode register, then read it back
  task automatic set_mode(input mode_t m);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= swdd_pkg::REG_SCREEN_MODE;
    pwdata  <= pdata_t'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly offsets inside the pixel and attribute areas of either file
  function automatic offset_t rand_offset;
    int r;
    r = $urandom_range(99);
    if (r < 30) return offset_t'($urandom_range(6143));
    if (r < 45) return offset_t'(6144 + $urandom_range(767));
    if (r < 70) return offset_t'(8192 + $urandom_range(6143));
    if (r < 82) return offset_t'(14336 + $urandom_range(767));
    if (r < 90) return offset_t'($urandom_range(1) ? 6912 + $urandom_range(1279)
                                                   : 15104 + $urandom_range(1279));
    return offset_t'($urandom_range(16383));
  endfunction

  initial begin : main
    mode_t m;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: area edges in the reset mode
    send_write(14'd0);
    send_write(14'd31);
    send_write(14'd6143);
    send_write(14'd6144);
    send_write(14'd6880);
    send_write(14'd6911);
    send_write(14'd6912);
    send_write(14'd8192);
    send_write(14'd16383);
    drain();
    set_mode(swdd_pkg::MODE_ALT_FILE);
    send_write(14'd8192);
    send_write(14'd14335);
    send_write(14'd14336);
    send_write(14'd15103);
    send_write(14'd15104);
    send_write(14'd6144);
    drain();
    set_mode(swdd_pkg::MODE_EXT_COL_ALT);
    send_write(14'd14336);
    send_write(14'd100);
    send_write(14'd8200);
    drain();
    // Unused mode code: nothing shows
    set_mode(4'd15);
    send_write(14'd0);
    send_write(14'd6144);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 9) m = mode_t'(p);
      else if (p == 9) m = 4'd15;
      else m = mode_t'(9 + $urandom_range(5));
      set_mode(m);
      if (p < 4) begin
        tx_idle_pct = 18;
        rx_idle_pct = 82;
      end else if (p < 8) begin
        tx_idle_pct = 82;
        rx_idle_pct = 18;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Stall the receiver so the queue fills and full backs up the input
      if (p == 8) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_write(rand_offset());
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
